// ----- rtl/s64alu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s64alu_pkg
// Shared types and constants for the pipelined signed 64-bit ALU.
// ----------------------------------------------------------------------------
package s64alu_pkg;

  localparam int unsigned DataW = 64;
  localparam int unsigned OpW   = 3;
  localparam int unsigned DivStages = 32;
  localparam int unsigned BitsPerStage = DataW / DivStages;

  typedef enum logic [OpW-1:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_QUO = 3'd3,
    OP_REM = 3'd4
  } opcode_t;

  typedef struct packed {
    logic             valid;
    logic [OpW-1:0]   op;
    logic             special;
    logic [DataW-1:0] special_val;
    logic             zdiv;
    logic             ovf;
    logic             neg_q;
    logic             neg_r;
  } div_ctl_t;

endpackage

// ----- rtl/s64alu_mul.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s64alu_mul
// Low 64 bits of a 64x64 product, from 32x32 partial products in three stages.
// ----------------------------------------------------------------------------
module s64alu_mul (
  input  logic                          clk,
  input  logic [s64alu_pkg::DataW-1:0]  a,
  input  logic [s64alu_pkg::DataW-1:0]  b,
  output logic [s64alu_pkg::DataW-1:0]  p
);

  logic [63:0] ll_r, ll_nxt;
  logic [31:0] lh_r, lh_nxt;
  logic [31:0] hl_r, hl_nxt;
  logic [63:0] p_r, p_nxt;
  logic [63:0] ll2_r;
  logic [31:0] cross_r;

  assign ll_nxt = {32'd0, a[31:0]} * {32'd0, b[31:0]};
  assign lh_nxt = a[31:0] * b[63:32];
  assign hl_nxt = a[63:32] * b[31:0];
  assign p_nxt  = ll2_r + {cross_r, 32'd0};

  always_ff @(posedge clk) begin
    ll_r    <= ll_nxt;
    lh_r    <= lh_nxt;
    hl_r    <= hl_nxt;
    ll2_r   <= ll_r;
    cross_r <= lh_r + hl_r;
    p_r     <= p_nxt;
  end

  assign p = p_r;

endmodule

// ----- rtl/s64alu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s64alu_div
// Pipelined restoring divider on magnitudes, two quotient bits per stage.
// ----------------------------------------------------------------------------
module s64alu_div (
  input  logic                          clk,
  input  logic                          rst_n,
  input  s64alu_pkg::div_ctl_t          ctl_in,
  input  logic [s64alu_pkg::DataW-1:0]  ma,
  input  logic [s64alu_pkg::DataW-1:0]  mb,
  output s64alu_pkg::div_ctl_t          ctl_out,
  output logic [s64alu_pkg::DataW-1:0]  quo,
  output logic [s64alu_pkg::DataW-1:0]  rem
);

  localparam int unsigned N = s64alu_pkg::DivStages;
  localparam int unsigned K = s64alu_pkg::BitsPerStage;
  localparam int unsigned W = s64alu_pkg::DataW;

  s64alu_pkg::div_ctl_t ctl_r [N];
  logic [W-1:0] q_r [N];
  logic [W-1:0] r_r [N];
  logic [W-1:0] d_r [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [W-1:0] q_in, r_in, d_in;
    logic [W-1:0] q_nxt;
    logic [W:0]   r_nxt;
    s64alu_pkg::div_ctl_t c_in;
    if (s == 0) begin : g_first
      assign q_in = ma;
      assign r_in = '0;
      assign d_in = mb;
      assign c_in = ctl_in;
    end else begin : g_rest
      assign q_in = q_r[s-1];
      assign r_in = r_r[s-1];
      assign d_in = d_r[s-1];
      assign c_in = ctl_r[s-1];
    end
    always_comb begin
      logic [W:0]   rr;
      logic [W-1:0] qq;
      logic [W:0]   diff;
      rr = {1'b0, r_in};
      qq = q_in;
      for (int k = 0; k < K; k++) begin
        rr = {rr[W-1:0], qq[W-1]};
        qq = {qq[W-2:0], 1'b0};
        diff = rr - {1'b0, d_in};
        if (!diff[W]) begin
          rr = diff;
          qq[0] = 1'b1;
        end
      end
      q_nxt = qq;
      r_nxt = rr;
    end
    always_ff @(posedge clk) begin
      q_r[s] <= q_nxt;
      r_r[s] <= r_nxt[W-1:0];
      d_r[s] <= d_in;
      if (!rst_n) begin
        ctl_r[s] <= '0;
      end else begin
        ctl_r[s] <= c_in;
      end
    end
  end

  assign ctl_out = ctl_r[N-1];
  assign quo = q_r[N-1];
  assign rem = r_r[N-1];

endmodule

// ----- rtl/signed_64bit_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_64bit_alu
// Fully pipelined signed 64-bit add, subtract, multiply, quotient, remainder.
// ----------------------------------------------------------------------------
// The block takes one item every cycle and never asserts busy. Every item
// appears on the result ports in order, for one cycle with out_valid, after
// passing the input register, the 32-stage divider (two quotient bits per
// stage) and the output register.
// Shorter operations are delayed to match. The receiver cannot stall the result.
module signed_64bit_alu (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic [s64alu_pkg::OpW-1:0]          in_opcode,
  input  logic signed [s64alu_pkg::DataW-1:0] in_operand_a,
  input  logic signed [s64alu_pkg::DataW-1:0] in_operand_b,
  output logic                                out_valid,
  output logic signed [s64alu_pkg::DataW-1:0] out_value,
  output logic                                out_zero_divisor,
  output logic                                out_overflowed
);

  localparam int unsigned W = s64alu_pkg::DataW;
  localparam int unsigned DN = s64alu_pkg::DivStages;

  s64alu_pkg::div_ctl_t ctl_nxt, ctl_r, dctl;
  logic [W-1:0] a_r, b_r, ma_r, mb_r, quo, rem, p;
  logic [W-1:0] simple_nxt, simple_r;
  logic [W-1:0] sv [DN];
  logic [W-1:0] value_nxt, value_r;
  logic zdiv_r, ovf_r, valid_r;
  logic [2:0] mul_flag;

  assign busy = 1'b0;

  always_comb begin
    ctl_nxt = '0;
    ctl_nxt.valid = start;
    ctl_nxt.op = in_opcode;
    ctl_nxt.neg_q = in_operand_a[W-1] ^ in_operand_b[W-1];
    ctl_nxt.neg_r = in_operand_a[W-1];
    if (in_opcode == s64alu_pkg::OP_QUO || in_opcode == s64alu_pkg::OP_REM) begin
      if (in_operand_b == '0) begin
        ctl_nxt.special = 1'b1;
        ctl_nxt.zdiv = 1'b1;
        ctl_nxt.special_val = (in_opcode == s64alu_pkg::OP_QUO) ? '1 : in_operand_a;
      end else if (in_operand_a == {1'b1, {(W-1){1'b0}}} && in_operand_b == '1) begin
        ctl_nxt.special = 1'b1;
        ctl_nxt.ovf = (in_opcode == s64alu_pkg::OP_QUO);
        ctl_nxt.special_val = (in_opcode == s64alu_pkg::OP_QUO) ? in_operand_a : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r <= ctl_nxt;
    end
    a_r <= in_operand_a;
    b_r <= in_operand_b;
    ma_r <= in_operand_a[W-1] ? -in_operand_a : in_operand_a;
    mb_r <= in_operand_b[W-1] ? -in_operand_b : in_operand_b;
  end

  always_comb begin
    case (ctl_r.op)
      s64alu_pkg::OP_ADD: simple_nxt = a_r + b_r;
      s64alu_pkg::OP_SUB: simple_nxt = a_r - b_r;
      default:            simple_nxt = '0;
    endcase
  end

  s64alu_mul u_mul (.clk(clk), .a(a_r), .b(b_r), .p(p));

  s64alu_div u_div (
    .clk(clk), .rst_n(rst_n), .ctl_in(ctl_r), .ma(ma_r), .mb(mb_r),
    .ctl_out(dctl), .quo(quo), .rem(rem)
  );

  always_ff @(posedge clk) begin
    mul_flag <= {mul_flag[1:0], ctl_r.op == s64alu_pkg::OP_MUL};
  end

  for (genvar i = 0; i < DN; i++) begin : g_dly
    if (i == 0) begin : g_head
      always_ff @(posedge clk) begin
        sv[i] <= simple_nxt;
      end
    end else if (i == 3) begin : g_mul
      always_ff @(posedge clk) begin
        sv[i] <= mul_flag[2] ? p : sv[i-1];
      end
    end else begin : g_pass
      always_ff @(posedge clk) begin
        sv[i] <= sv[i-1];
      end
    end
  end

  assign simple_r = sv[DN-1];

  always_comb begin
    case (dctl.op)
      s64alu_pkg::OP_QUO: value_nxt = dctl.special ? dctl.special_val :
                                      (dctl.neg_q ? -quo : quo);
      s64alu_pkg::OP_REM: value_nxt = dctl.special ? dctl.special_val :
                                      (dctl.neg_r ? -rem : rem);
      default:            value_nxt = simple_r;
    endcase
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
    zdiv_r <= dctl.zdiv;
    ovf_r <= dctl.ovf;
    valid_r <= rst_n ? dctl.valid : 1'b0;
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_zero_divisor = zdiv_r;
  assign out_overflowed = ovf_r;

endmodule

// ----- rtl/s64alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s64alu_checker
// Port-level checks on the signed 64-bit ALU.
// ----------------------------------------------------------------------------
module s64alu_checker (
  input logic clk,
  input logic rst_n,
  input logic busy,
  input logic out_valid,
  input logic out_zero_divisor,
  input logic out_overflowed
);

  a_never_busy: assert property (@(posedge clk) busy == 1'b0)
    else $error("busy asserted");

  a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_zero_divisor && out_overflowed))
    else $error("both flags set");

  a_no_out_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result after reset");

endmodule

bind signed_64bit_alu s64alu_checker u_chk (
  .clk(clk), .rst_n(rst_n), .busy(busy), .out_valid(out_valid),
  .out_zero_divisor(out_zero_divisor), .out_overflowed(out_overflowed)
);

// ----- dv/alu_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alu_checker
// Watches the item and result channels of the signed 64-bit ALU, predicts
// each result from the accepted item, and compares results in order.
// ----------------------------------------------------------------------------
module alu_checker (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic                                busy,
  input  logic [s64alu_pkg::OpW-1:0]          in_opcode,
  input  logic signed [s64alu_pkg::DataW-1:0] in_operand_a,
  input  logic signed [s64alu_pkg::DataW-1:0] in_operand_b,
  input  logic                                out_valid,
  input  logic signed [s64alu_pkg::DataW-1:0] out_value,
  input  logic                                out_zero_divisor,
  input  logic                                out_overflowed,
  output int                                  fail_count,
  output int                                  pending
);

  localparam int unsigned DataW = s64alu_pkg::DataW;
  localparam int unsigned OpW   = s64alu_pkg::OpW;

  typedef struct packed {
    logic [DataW-1:0] value;
    logic             zdiv;
    logic             ovf;
  } alu_result_t;

  localparam logic [DataW-1:0] MinVal  = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] AllOnes = '1;

  alu_result_t expected_q[$];
  int fails = 0;

  function automatic alu_result_t compute_result(logic [OpW-1:0] op,
                                                 logic [DataW-1:0] a,
                                                 logic [DataW-1:0] b);
    alu_result_t res;
    logic [DataW-1:0] ma;
    logic [DataW-1:0] mb;
    logic [DataW-1:0] q;
    logic [DataW-1:0] r;
    res = '0;
    case (op)
      s64alu_pkg::OP_ADD: res.value = a + b;
      s64alu_pkg::OP_SUB: res.value = a - b;
      s64alu_pkg::OP_MUL: res.value = a * b;
      s64alu_pkg::OP_QUO, s64alu_pkg::OP_REM: begin
        if (b == '0) begin
          res.zdiv  = 1'b1;
          res.value = (op == s64alu_pkg::OP_QUO) ? AllOnes : a;
        end else if (a == MinVal && b == AllOnes) begin
          res.value = (op == s64alu_pkg::OP_QUO) ? MinVal : '0;
          res.ovf   = (op == s64alu_pkg::OP_QUO);
        end else begin
          ma = a[DataW-1] ? -a : a;
          mb = b[DataW-1] ? -b : b;
          q  = ma / mb;
          r  = ma % mb;
          if (op == s64alu_pkg::OP_QUO) res.value = (a[DataW-1] != b[DataW-1]) ? -q : q;
          else res.value = a[DataW-1] ? -r : r;
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  assign fail_count = fails;

  always @(posedge clk) begin
    alu_result_t exp_res;
    if (rst_n && start && !busy)
      expected_q.push_back(compute_result(in_opcode, in_operand_a, in_operand_b));
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        fails++;
        if (fails <= 10) $display("checker: unexpected result %h", out_value);
      end else begin
        exp_res = expected_q.pop_front();
        if (exp_res.value !== out_value || exp_res.zdiv !== out_zero_divisor ||
            exp_res.ovf !== out_overflowed) begin
          fails++;
          if (fails <= 10)
            $display("checker: mismatch exp %h/%b/%b got %h/%b/%b", exp_res.value,
                     exp_res.zdiv, exp_res.ovf, out_value, out_zero_divisor,
                     out_overflowed);
        end
      end
    end
    pending = expected_q.size();
  end
endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives directed items back to back and random items, most with random gaps,
// into the signed 64-bit ALU; the checker predicts and compares each result.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned DataW = s64alu_pkg::DataW;
  localparam int unsigned OpW   = s64alu_pkg::OpW;
  localparam int RandItems = 1530;
  localparam int Latency   = 34;
  localparam int WatchLimit = 2000;
  localparam logic [DataW-1:0] MinVal = {1'b1, {(DataW-1){1'b0}}};
  localparam logic [DataW-1:0] MaxVal = {1'b0, {(DataW-1){1'b1}}};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [OpW-1:0] in_opcode = '0;
  logic signed [DataW-1:0] in_operand_a = '0;
  logic signed [DataW-1:0] in_operand_b = '0;
  logic out_valid;
  logic signed [DataW-1:0] out_value;
  logic out_zero_divisor;
  logic out_overflowed;
  int fail_count;
  int pending;
  int idle_cycles = 0;
  int item_count = 0;

  always #10 clk = ~clk;

  signed_64bit_alu i_dut (.*);
  alu_checker i_checker (.*);

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic logic [DataW-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return MinVal;
      1: return MaxVal;
      2: return '0;
      3: return '1;
      4: return DataW'($urandom_range(0, 20));
      5: return -DataW'($urandom_range(1, 20));
      6: return {{32{1'b0}}, 32'($urandom)};
      7: return {{32{1'b1}}, 32'($urandom)};
      default: return {32'($urandom), 32'($urandom)};
    endcase
  endfunction

  task automatic send_item(logic [OpW-1:0] op, logic [DataW-1:0] a,
                           logic [DataW-1:0] b, bit gaps);
    int n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (n) @(negedge clk);
    end
    start <= 1'b1;
    in_opcode <= op;
    in_operand_a <= a;
    in_operand_b <= b;
    @(posedge clk);
    while (busy) @(posedge clk);
    item_count++;
    @(negedge clk);
  endtask

  initial begin
    logic [OpW-1:0] op;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    for (int o = 0; o < 8; o++) send_item(OpW'(o), MinVal, MaxVal, 1'b0);
    send_item(s64alu_pkg::OP_QUO, MinVal, '1, 1'b0);
    send_item(s64alu_pkg::OP_REM, MinVal, '1, 1'b0);
    send_item(s64alu_pkg::OP_QUO, 64'd7, '0, 1'b0);
    send_item(s64alu_pkg::OP_REM, -64'd7, '0, 1'b0);
    send_item(s64alu_pkg::OP_QUO, -64'd7, 64'd2, 1'b0);
    send_item(s64alu_pkg::OP_REM, -64'd7, 64'd2, 1'b0);
    send_item(s64alu_pkg::OP_REM, 64'd7, -64'd2, 1'b0);
    send_item(s64alu_pkg::OP_MUL, MaxVal, MaxVal, 1'b0);
    send_item(s64alu_pkg::OP_ADD, MaxVal, 64'd1, 1'b0);
    send_item(s64alu_pkg::OP_SUB, MinVal, 64'd1, 1'b0);
    for (int i = 0; i < RandItems; i++) begin
      op = ($urandom_range(0, 15) == 0) ? OpW'($urandom_range(5, 7))
                                        : OpW'($urandom_range(0, 4));
      send_item(op, pick_operand(), pick_operand(), i < RandItems - 200);
    end
    start <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (Latency + 5) @(negedge clk);
    $display("tb: sent %0d items covering all opcodes, unused codes and division corners",
             item_count);
    if (fail_count == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule

// ----- files.f -----
rtl/s64alu_pkg.sv
rtl/s64alu_mul.sv
rtl/s64alu_div.sv
rtl/signed_64bit_alu.sv
rtl/s64alu_checker.sv
dv/alu_checker.sv
dv/tb.sv
